[rtl/calc_system_port_controller_unit_macros.svh]
// Assertion macros for the system port controller.
// Taken in by the top level; relies on nothing else.
`ifndef CALC_SYSTEM_PORT_CONTROLLER_UNIT_MACROS_SVH
`define CALC_SYSTEM_PORT_CONTROLLER_UNIT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define CSPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define CSPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cspc_pkg.sv]
// Shared types, codes and tables of the system port controller.
// No dependencies; used by the interfaces, the register file and the top level.
package cspc_pkg;

   // Operation codes of an input beat; codes 5 to 7 do nothing.
   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_TIMER1 = 3'd2,
      OP_TIMER2 = 3'd3,
      OP_ONKEY  = 3'd4
   } op_type;

   // Units that an access is handed over to.
   typedef enum logic [1:0] {
      UNIT_LOCAL  = 2'd0,
      UNIT_LINK   = 2'd1,
      UNIT_KEYPAD = 2'd2,
      UNIT_LCD    = 2'd3
   } unit_type;

   // Register selection by the low three port bits (ports below 0x10).
   localparam logic [2:0] PSEL_BATT     = 3'd2;
   localparam logic [2:0] PSEL_INT_CTL  = 3'd3;
   localparam logic [2:0] PSEL_INT_STAT = 3'd4;  // read side
   localparam logic [2:0] PSEL_MEM_CTL  = 3'd4;  // write side
   localparam logic [2:0] PSEL_PROT_SEL = 3'd5;
   localparam logic [2:0] PSEL_BANK_A   = 3'd6;
   localparam logic [2:0] PSEL_BANK_B   = 3'd7;

   // Ports that get special handling.
   localparam logic [4:0] PORT_LINK0     = 5'h00;
   localparam logic [4:0] PORT_LINK1     = 5'h08;
   localparam logic [4:0] PORT_KEY0      = 5'h01;
   localparam logic [4:0] PORT_KEY1      = 5'h09;
   localparam logic [4:0] PORT_LINKDAT0  = 5'h05;
   localparam logic [4:0] PORT_LINKDAT1  = 5'h0d;
   localparam logic [3:0] PORT_FLASH_HI4 = 4'ha;   // ports 0x14, 0x15
   localparam logic [3:0] PORT_NOEXEC_HI4 = 4'hb;  // ports 0x16, 0x17

   // Protection select codes for the no-exec masks.
   localparam logic [2:0] PROT_LOW  = 3'd0;
   localparam logic [2:0] PROT_MID  = 3'd1;
   localparam logic [2:0] PROT_HIGH = 3'd2;
   localparam logic [2:0] PROT_RAM  = 3'd7;

   localparam logic [5:0] PAGE_RAM0 = 6'h20;

   typedef struct packed {
      logic [2:0] operation;
      logic [4:0] port;
      logic [7:0] write_data;
      logic [7:0] battery_level;
      logic       on_key_down;
      logic       link_active_irq;
      logic       protect_unlocked;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [1:0]  forward_unit;
      logic [5:0]  bank1_page;
      logic [5:0]  bank2_page;
      logic [5:0]  bank3_page;
      logic [13:0] timer_period;
      logic [2:0]  irq_flags;
      logic        power_on_halt;
      logic        link_int_enable;
      logic [21:0] noexec_masks;
   } rsp_type;

   typedef struct packed {
      logic [7:0] interrupt_control;
      logic [7:0] memory_control;
      logic [2:0] protect_select;
      logic [6:0] bank_a_select;
      logic [6:0] bank_b_select;
      logic       flash_unlock;
      logic [2:0] pending_irqs;
      logic [7:0] noexec_low;
      logic [7:0] noexec_mid;
      logic [3:0] noexec_high;
      logic [1:0] noexec_ram;
   } state_type;

   function automatic logic [7:0] batt_threshold(input logic [1:0] sel);
      logic [7:0] thr;
      unique case (sel)
         2'd0: thr = 8'd33;
         2'd1: thr = 8'd39;
         2'd2: thr = 8'd36;
         2'd3: thr = 8'd43;
         default: thr = 8'd33;
      endcase
      return thr;
   endfunction

   function automatic logic [13:0] timer_period_of(input logic [1:0] sel);
      logic [13:0] per;
      unique case (sel)
         2'd0: per = 14'd1786;
         2'd1: per = 14'd4032;
         2'd2: per = 14'd5882;
         2'd3: per = 14'd8474;
         default: per = 14'd1786;
      endcase
      return per;
   endfunction

   // Page that a bank select value maps: RAM page or low five bits.
   function automatic logic [5:0] bank_page(input logic [6:0] sel);
      return sel[6] ? {PAGE_RAM0[5:1], sel[0]} : {1'b0, sel[4:0]};
   endfunction

   function automatic unit_type port_unit(input logic [4:0] p);
      unit_type u;
      priority if (p == PORT_LINK0 || p == PORT_LINK1) begin
         u = UNIT_LINK;
      end else if (p == PORT_KEY0 || p == PORT_KEY1) begin
         u = UNIT_KEYPAD;
      end else if (p[4] && !p[2]) begin
         u = UNIT_LCD;
      end else begin
         u = UNIT_LOCAL;
      end
      return u;
   endfunction

endpackage

[rtl/cspc_req_if.sv]
// Input channel of the system port controller: valid/ready plus one access beat.
// Depends on cspc_pkg.
interface cspc_req_if
   import cspc_pkg::*;
   ;
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/cspc_rsp_if.sv]
// Result channel of the system port controller: valid/ready plus one result beat.
// Depends on cspc_pkg.
interface cspc_rsp_if
   import cspc_pkg::*;
   ;
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/cspc_regfile.sv]
// Register file of the system port controller: port decode, register
// updates and result formatting. Depends on cspc_pkg.
module cspc_regfile
   import cspc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      update,
   input  req_type   item,
   output rsp_type   result,
   output state_type state
);

   state_type state_ff;
   state_type state_in;
   logic [7:0] rd;
   unit_type   fwd;
   logic [5:0] page_a;
   logic [5:0] page_b;
   logic [1:0] batt_bits;

   always_comb begin
      state_in  = state_ff;
      rd        = 8'd0;
      fwd       = UNIT_LOCAL;
      batt_bits = (item.battery_level >= batt_threshold(state_ff.memory_control[7:6]))
                  ? 2'd3 : 2'd2;
      unique case (item.operation)
         OP_READ: begin
            fwd = port_unit(item.port);
            if (item.port == PORT_LINKDAT0 || item.port == PORT_LINKDAT1) begin
               fwd = UNIT_LINK;
            end
            if (fwd == UNIT_LOCAL && !item.port[4]) begin
               unique case (item.port[2:0])
                  PSEL_BATT: rd = {2'b00, state_ff.protect_select, state_ff.flash_unlock,
                                   batt_bits};
                  PSEL_INT_CTL: rd = state_ff.interrupt_control;
                  PSEL_INT_STAT: rd = {3'b000, item.link_active_irq, !item.on_key_down,
                                       state_ff.pending_irqs};
                  PSEL_BANK_A: rd = {1'b0, state_ff.bank_a_select};
                  PSEL_BANK_B: rd = {1'b0, state_ff.bank_b_select};
                  default: rd = 8'd0;
               endcase
            end
         end
         OP_WRITE: begin
            fwd = port_unit(item.port);
            if (fwd == UNIT_LOCAL) begin
               if (!item.port[4]) begin
                  unique case (item.port[2:0])
                     PSEL_INT_CTL: begin
                        // clear the flags whose enable goes low
                        state_in.pending_irqs      = state_ff.pending_irqs
                                                     & item.write_data[2:0];
                        state_in.interrupt_control = item.write_data;
                     end
                     PSEL_MEM_CTL:  state_in.memory_control = item.write_data;
                     PSEL_PROT_SEL: state_in.protect_select = item.write_data[2:0];
                     PSEL_BANK_A:   state_in.bank_a_select  = item.write_data[6:0];
                     PSEL_BANK_B:   state_in.bank_b_select  = item.write_data[6:0];
                     default: ;
                  endcase
               end else if (item.port[4:1] == PORT_FLASH_HI4) begin
                  if (item.protect_unlocked) begin
                     state_in.flash_unlock = item.write_data[0];
                  end
               end else if (item.port[4:1] == PORT_NOEXEC_HI4) begin
                  if (state_ff.flash_unlock && item.protect_unlocked) begin
                     unique case (state_ff.protect_select)
                        PROT_LOW:  state_in.noexec_low  = item.write_data;
                        PROT_MID:  state_in.noexec_mid  = item.write_data;
                        PROT_HIGH: state_in.noexec_high = item.write_data[3:0];
                        PROT_RAM:  state_in.noexec_ram  = {item.write_data[5],
                                                           item.write_data[0]};
                        default: ;
                     endcase
                  end
               end
            end
         end
         OP_TIMER1: begin
            if (state_ff.interrupt_control[1]) state_in.pending_irqs[1] = 1'b1;
         end
         OP_TIMER2: begin
            if (state_ff.interrupt_control[2]) state_in.pending_irqs[2] = 1'b1;
         end
         OP_ONKEY: begin
            if (state_ff.interrupt_control[0]) state_in.pending_irqs[0] = 1'b1;
         end
         default: ;
      endcase
   end

   // Result reports the state as left by this beat.
   always_comb begin
      page_a = bank_page(state_in.bank_a_select);
      page_b = bank_page(state_in.bank_b_select);
      result.read_data    = rd;
      result.forward_unit = fwd;
      if (state_in.memory_control[0]) begin
         result.bank1_page = {page_a[5:1], 1'b0};
         result.bank2_page = page_a;
         result.bank3_page = page_b;
      end else begin
         result.bank1_page = page_a;
         result.bank2_page = page_b;
         result.bank3_page = PAGE_RAM0;
      end
      result.timer_period    = timer_period_of(state_in.memory_control[2:1]);
      result.irq_flags       = state_in.pending_irqs;
      result.power_on_halt   = state_in.interrupt_control[3];
      result.link_int_enable = state_in.interrupt_control[4];
      result.noexec_masks    = {state_in.noexec_ram, state_in.noexec_high,
                                state_in.noexec_mid, state_in.noexec_low};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

[rtl/calc_system_port_controller_unit.sv]
// System port controller of a handheld calculator, top level.
// Depends on cspc_pkg, cspc_req_if, cspc_rsp_if, cspc_regfile and the macro header.

// The block takes one port access or event beat per clock, unless the sink
// stalls, and returns one result beat for each. A beat lands in an input
// register, then one pass of decode and register update produces its result
// into an output register, from which it is presented to the sink. While the
// sink does not stall, the sustained rate is one beat per cycle, set by the
// register file updating its state as each beat advances, whose new state
// feeds the next beat directly. While the output register holds a result that
// the sink has not taken, the input register still takes one more beat; ready
// drops only when both are full and the sink stalls.
// Link, keypad and LCD accesses are only tagged in forward_unit; read_data is
// zero for them and for events. Reset clears every register of the file.
`include "calc_system_port_controller_unit_macros.svh"

module calc_system_port_controller_unit
   import cspc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cspc_req_if.sink   req_bus,
   cspc_rsp_if.source rsp_bus
);

   // Input stage.
   req_type   item_ff;
   req_type   item_in;
   logic      item_valid_ff;
   logic      item_valid_in;

   // Output stage.
   rsp_type   out_ff;
   logic      out_valid_ff;
   logic      out_valid_in;

   rsp_type   result;
   state_type state;
   logic      advance;
   logic      take;

   // Advance the input beat when the output register is free or drains now.
   assign advance = item_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;

   always_comb begin
      item_in       = take ? req_bus.data : item_ff;
      item_valid_in = take || (item_valid_ff && !advance);
      out_valid_in  = advance || (out_valid_ff && !rsp_bus.ready);
   end

   cspc_regfile u_regfile (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .item   (item_ff),
      .result (result),
      .state  (state)
   );

   // Hold payload registers without reset; only the valid flags clear.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         out_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;

   // An empty output stage only fills from an advancing input beat.
   `CSPC_ASSERT_NEXT(a_out_fill, clock, reset, !out_valid_ff && !advance, !out_valid_ff, "result beat appeared without an input beat")
   // A timer1 flag only rises on an enabled timer1 event.
   `CSPC_ASSERT_NEXT(a_timer1_flag, clock, reset, !state.pending_irqs[1] && !(advance && item_ff.operation == OP_TIMER1), !state.pending_irqs[1], "timer1 flag rose without its event")
   // No-exec masks change only on an unlocked protected write.
   `CSPC_ASSERT_NEXT(a_noexec_lock, clock, reset, !(advance && item_ff.operation == OP_WRITE && state.flash_unlock && item_ff.protect_unlocked), $stable(state.noexec_low) && $stable(state.noexec_mid) && $stable(state.noexec_high) && $stable(state.noexec_ram), "no-exec mask changed while locked")
   // Forwarded accesses leave the register file alone.
   `CSPC_ASSERT_NEXT(a_fwd_no_update, clock, reset, advance && result.forward_unit != UNIT_LOCAL, $stable(state), "forwarded access changed local state")
   // A forwarded access never returns local read data.
   `CSPC_ASSERT(a_fwd_zero_read, clock, reset, !(out_valid_ff && out_ff.forward_unit != UNIT_LOCAL) || out_ff.read_data == 8'd0, "forwarded beat carries read data")

endmodule
